// ----- rtl/assert_macros.svh -----
// Assertion helpers. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define RBL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication
`define RBL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/rbl_pkg.sv -----
`timescale 1ns / 1ps

package rbl_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 17;
    localparam int SCALE_W  = 31;
    localparam int COEF_W   = 32;
    localparam int Q_W      = 32;
    localparam int XPROD_W  = 48;
    localparam int PROD_W   = 64;
    localparam int FBSUM_W  = 66;
    localparam int FB_W     = 36;
    localparam int XS_W     = 34;
    localparam int YSUM_W   = 38;
    localparam int CFG_IDX_W = 2;

    localparam logic [XPROD_W-1:0] X_ROUND  = 48'h2000;
    localparam logic [FBSUM_W-1:0] FB_ROUND = 66'h2000_0000;
    localparam logic [Q_W-1:0]     Q_MAX    = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0]     Q_MIN    = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_SCALE     = 2'd0,
        CFG_FEEDBACK_RECENT = 2'd1,
        CFG_FEEDBACK_OLDER  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                       channel;
        logic signed [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic                  out_channel;
        logic signed [Q_W-1:0] envelope;
    } out_item_t;

    // One memory word: the whole filter history of one channel
    typedef struct packed {
        logic signed [Q_W-1:0] x_old;
        logic signed [Q_W-1:0] x_rec;
        logic signed [Q_W-1:0] y_old;
        logic signed [Q_W-1:0] y_rec;
    } chan_state_t;

    typedef struct packed {
        logic s1_free;
        logic hazard;
    } pipe_ctrl_t;

endpackage

// ----- rtl/rectified_biquad_lowpass_envelope_top.sv -----
`timescale 1ns / 1ps

// Rectified second-order low-pass envelope detector, CHANNELS independent
// filters whose history lives in one state memory (one word per channel,
// cleared at reset by per-entry valid bits, so no clearing pass). A transaction
// passes through stages 1, 2 and 3 and the output register to out_data. A new
// transaction is taken every cycle while out_stall does not hold the pipeline
// and its channel differs from those of the transactions still in flight; a
// transaction on a busy channel waits for its write-back, so samples on one
// channel are bounded by the loop: memory read, 32x32 multiply, feedback
// reduction, then sum, clamp and write-back. Configuration writes (cfg_ready
// is always high) must be made while no transaction is in flight.

module rectified_biquad_lowpass_envelope_top
    import rbl_pkg::*;
#(
    parameter int CHANNELS = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [Q_W-1:0]       cfg_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [SCALE_W-1:0]       input_scale_reg;
    logic signed [COEF_W-1:0] fb_recent_reg;
    logic signed [COEF_W-1:0] fb_older_reg;

    logic                 accept;
    logic [IDX_W-1:0]     new_idx;
    logic [MAG_W-1:0]     sx;
    logic [MAG_W-1:0]     mag;
    pipe_ctrl_t           ctrl;
    chan_state_t          st_rd;
    chan_state_t          wr_data;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_scale_reg <= '0;
            fb_recent_reg   <= '0;
            fb_older_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_INPUT_SCALE:     input_scale_reg <= cfg_data[SCALE_W-1:0];
                CFG_FEEDBACK_RECENT: fb_recent_reg   <= cfg_data;
                CFG_FEEDBACK_OLDER:  fb_older_reg    <= cfg_data;
                default:             ;
            endcase
        end
    end

    // channel modulo CHANNELS; the field is one bit wide
    assign new_idx = (CHANNELS == 1) ? '0 : IDX_W'(in_data.channel);

    assign sx  = {in_data.sample[SAMPLE_W-1], in_data.sample};
    assign mag = in_data.sample[SAMPLE_W-1] ? (MAG_W'(0) - sx) : sx;

    assign in_stall = !(ctrl.s1_free && !ctrl.hazard);
    assign accept   = in_valid && !in_stall;

    rbl_mem #(
        .DEPTH (CHANNELS),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_idx  (new_idx),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_data (st_rd)
    );

    rbl_pipe #(
        .IDX_W (IDX_W)
    ) u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (accept),
        .new_idx     (new_idx),
        .new_chan    (in_data.channel),
        .new_mag     (mag),
        .input_scale (input_scale_reg),
        .fb_recent   (fb_recent_reg),
        .fb_older    (fb_older_reg),
        .st_rd       (st_rd),
        .wr_en       (wr_en),
        .wr_idx      (wr_idx),
        .wr_data     (wr_data),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_data    (out_data),
        .ctrl        (ctrl)
    );

endmodule

// ----- rtl/rbl_mem.sv -----
`timescale 1ns / 1ps

module rbl_mem
    import rbl_pkg::*;
#(
    parameter int DEPTH = 2,
    parameter int IDX_W = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  chan_state_t      wr_data,
    output chan_state_t      rd_data
);

    chan_state_t           mem [DEPTH];
    logic [DEPTH-1:0]      vld_reg;
    chan_state_t           rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    // Entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_idx] <= 1'b1;
        end
    end

    // Write-through on a read of the entry being written in the same cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_idx == rd_idx))
            begin
                rd_data_reg <= wr_data;
            end
            else if (vld_reg[rd_idx])
            begin
                rd_data_reg <= mem[rd_idx];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/rbl_pipe.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rbl_pipe
    import rbl_pkg::*;
#(
    parameter int IDX_W = 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     take,
    input  logic [IDX_W-1:0]         new_idx,
    input  logic                     new_chan,
    input  logic [MAG_W-1:0]         new_mag,
    input  logic [SCALE_W-1:0]       input_scale,
    input  logic signed [COEF_W-1:0] fb_recent,
    input  logic signed [COEF_W-1:0] fb_older,
    input  chan_state_t              st_rd,
    output logic                     wr_en,
    output logic [IDX_W-1:0]         wr_idx,
    output chan_state_t              wr_data,
    input  logic                     out_stall,
    output logic                     out_valid,
    output out_item_t                out_data,
    output pipe_ctrl_t               ctrl
);

    // stage 1: memory read in flight
    logic                  s1_v_reg, s1_v_next;
    logic                  ch1_reg;
    logic [IDX_W-1:0]      idx1_reg;
    logic [MAG_W-1:0]      mag1_reg;

    // stage 2: products
    logic                  s2_v_reg, s2_v_next;
    logic                  ch2_reg;
    logic [IDX_W-1:0]      idx2_reg;
    logic [XPROD_W-1:0]    px2_reg;
    logic signed [PROD_W-1:0] pr2_reg;
    logic signed [PROD_W-1:0] po2_reg;
    logic signed [Q_W-1:0] xo2_reg;
    logic signed [Q_W-1:0] xr2_reg;
    logic signed [Q_W-1:0] yr2_reg;

    // stage 3: reduced terms
    logic                  s3_v_reg, s3_v_next;
    logic                  ch3_reg;
    logic [IDX_W-1:0]      idx3_reg;
    logic [Q_W-1:0]        x2_3_reg;
    logic signed [FB_W-1:0] fb3_reg;
    logic signed [XS_W-1:0] xs3_reg;
    logic signed [Q_W-1:0] xr3_reg;
    logic signed [Q_W-1:0] yr3_reg;

    logic                  o_v_reg, o_v_next;
    out_item_t             o_data_reg;

    logic o_load, s3_go, s3_free, s2_go, s2_free, s1_go, s1_free;

    logic [XPROD_W-1:0]       px_next;
    logic signed [PROD_W-1:0] pr_next;
    logic signed [PROD_W-1:0] po_next;
    logic [XPROD_W-1:0]       xround;
    logic [Q_W-1:0]           x2_next;
    logic signed [FBSUM_W-1:0] fbsum;
    logic signed [XS_W-1:0]   xs_next;
    logic signed [YSUM_W-1:0] ysum;
    logic [Q_W-1:0]           y_sat;

    assign o_load  = !o_v_reg || !out_stall;
    assign s3_go   = s3_v_reg && o_load;
    assign s3_free = !s3_v_reg || o_load;
    assign s2_go   = s2_v_reg && s3_free;
    assign s2_free = !s2_v_reg || s3_free;
    assign s1_go   = s1_v_reg && s2_free;
    assign s1_free = !s1_v_reg || s2_free;

    // A channel may have one transaction in flight; stage 3 releases it on write-back
    assign ctrl.s1_free = s1_free;
    assign ctrl.hazard  = (s1_v_reg && (idx1_reg == new_idx))
                       || (s2_v_reg && (idx2_reg == new_idx))
                       || (s3_v_reg && (idx3_reg == new_idx) && !s3_go);

    always_comb
    begin
        s1_v_next = s1_v_reg;
        if (take)
        begin
            s1_v_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_v_next = 1'b0;
        end

        s2_v_next = s2_v_reg;
        if (s1_go)
        begin
            s2_v_next = 1'b1;
        end
        else if (s2_go)
        begin
            s2_v_next = 1'b0;
        end

        s3_v_next = s3_v_reg;
        if (s2_go)
        begin
            s3_v_next = 1'b1;
        end
        else if (s3_go)
        begin
            s3_v_next = 1'b0;
        end

        o_v_next = o_v_reg && out_stall;
        if (s3_go)
        begin
            o_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
            s2_v_reg <= s2_v_next;
            s3_v_reg <= s3_v_next;
            o_v_reg  <= o_v_next;
        end
    end

    // stage 1 -> 2: the three multiplies
    assign px_next = XPROD_W'(mag1_reg) * XPROD_W'(input_scale);
    assign pr_next = PROD_W'(fb_recent) * PROD_W'($signed(st_rd.y_rec));
    assign po_next = PROD_W'(fb_older) * PROD_W'($signed(st_rd.y_old));

    // stage 2 -> 3: round/saturate scaled input, round-shift feedback, sum x_old + 2*x_rec
    assign xround  = px2_reg + X_ROUND;
    assign x2_next = (|xround[XPROD_W-1:45]) ? Q_MAX : {1'b0, xround[44:14]};
    assign fbsum   = {{2{pr2_reg[PROD_W-1]}}, pr2_reg}
                   + {{2{po2_reg[PROD_W-1]}}, po2_reg}
                   + $signed(FB_ROUND);
    assign xs_next = {{2{xo2_reg[Q_W-1]}}, xo2_reg} + {xr2_reg[Q_W-1], xr2_reg, 1'b0};

    // stage 3: final sum and clamp
    assign ysum = {{(YSUM_W-FB_W){fb3_reg[FB_W-1]}}, fb3_reg}
                + {{(YSUM_W-XS_W){xs3_reg[XS_W-1]}}, xs3_reg}
                + {{(YSUM_W-Q_W){1'b0}}, x2_3_reg};

    always_comb
    begin
        if ((&ysum[YSUM_W-1:Q_W-1]) || !(|ysum[YSUM_W-1:Q_W-1]))
        begin
            y_sat = ysum[Q_W-1:0];
        end
        else if (ysum[YSUM_W-1])
        begin
            y_sat = Q_MIN;
        end
        else
        begin
            y_sat = Q_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ch1_reg  <= new_chan;
            idx1_reg <= new_idx;
            mag1_reg <= new_mag;
        end
        if (s1_go)
        begin
            ch2_reg  <= ch1_reg;
            idx2_reg <= idx1_reg;
            px2_reg  <= px_next;
            pr2_reg  <= pr_next;
            po2_reg  <= po_next;
            xo2_reg  <= st_rd.x_old;
            xr2_reg  <= st_rd.x_rec;
            yr2_reg  <= st_rd.y_rec;
        end
        if (s2_go)
        begin
            ch3_reg  <= ch2_reg;
            idx3_reg <= idx2_reg;
            x2_3_reg <= x2_next;
            fb3_reg  <= fbsum[FBSUM_W-1:30];
            xs3_reg  <= xs_next;
            xr3_reg  <= xr2_reg;
            yr3_reg  <= yr2_reg;
        end
        if (s3_go)
        begin
            o_data_reg.out_channel <= ch3_reg;
            o_data_reg.envelope    <= y_sat;
        end
    end

    assign wr_en         = s3_go;
    assign wr_idx        = idx3_reg;
    assign wr_data.x_old = xr3_reg;
    assign wr_data.x_rec = x2_3_reg;
    assign wr_data.y_old = yr3_reg;
    assign wr_data.y_rec = y_sat;

    assign out_valid = o_v_reg;
    assign out_data  = o_data_reg;

    `RBL_ASSERT_IMP(a_s1_s2_distinct, s1_v_reg && s2_v_reg, idx1_reg != idx2_reg)
    `RBL_ASSERT_IMP(a_s2_s3_distinct, s2_v_reg && s3_v_reg, idx2_reg != idx3_reg)
    `RBL_ASSERT_IMP(a_s1_s3_distinct, s1_v_reg && s3_v_reg, idx1_reg != idx3_reg)
    `RBL_ASSERT_NXT(a_wb_shows_result, s3_go, o_v_reg)

endmodule
